// ===== rtl/core/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int unsigned NumSets  = 1024;
  localparam int unsigned SetIdxW  = $clog2(NumSets);
  localparam int unsigned NumWays  = 8;
  localparam int unsigned WayW     = $clog2(NumWays);
  localparam int unsigned WayCntW  = 4;
  localparam int unsigned TagW     = 64;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned StampW   = 32;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  localparam logic [CfgIdxW-1:0] CfgSetBits   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWays      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBlockBits = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic capture;
    logic rd;
    logic ex;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/sacl_if.sv =====
// ----------------------------------------------------------------------------
// sacl_req_if / sacl_rsp_if
// Valid/ready channels for access requests and their outcomes.
// ----------------------------------------------------------------------------
interface sacl_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] address;

  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

interface sacl_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        miss;
  logic        eviction;
  logic        second_hit;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;

  modport source (output valid, hit, miss, eviction, second_hit, hit_total, miss_total,
                  eviction_total, input ready);
  modport sink   (input valid, hit, miss, eviction, second_hit, hit_total, miss_total,
                  eviction_total, output ready);
endinterface

// ===== rtl/core/set_assoc_lru_cache_model_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_top
// Set-associative cache model with LRU replacement and saturating totals.
// ----------------------------------------------------------------------------
// After reset the block clears its valid bits, one set per cycle over all
// sets, and takes no request until then. Each request then passes through
// capture and address split, a read of the whole set row from the
// set memory, and an update step that decides hit, fill or eviction and
// writes the row back, a modify's second access included. The result sits
// in an output register; the update of the next request waits until that
// register is taken.
module set_assoc_lru_cache_model_top import sacl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  sacl_req_if.sink            req_i,
  sacl_rsp_if.source          rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t st;

  sacl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  sacl_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .st_o             (st),
    .action_i         (req_i.action),
    .address_i        (req_i.address),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .hit_o            (rsp_o.hit),
    .miss_o           (rsp_o.miss),
    .eviction_o       (rsp_o.eviction),
    .second_hit_o     (rsp_o.second_hit),
    .hit_total_o      (rsp_o.hit_total),
    .miss_total_o     (rsp_o.miss_total),
    .eviction_total_o (rsp_o.eviction_total)
  );

  a_capture_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> cmd.rd)
    else $error("row read did not follow request capture");

  a_update_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ex |=> rsp_o.valid)
    else $error("row update did not present a result");

  a_outcome_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((rsp_o.hit ^ rsp_o.miss) && (!rsp_o.eviction || rsp_o.miss)))
    else $error("inconsistent hit, miss and eviction flags");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr, cmd.capture, cmd.rd, cmd.ex}))
    else $error("more than one datapath command at once");

endmodule

// ===== rtl/core/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: clearing pass, request capture, row read and row update.
// ----------------------------------------------------------------------------
module sacl_ctrl import sacl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StClr  = 4'b0001,
    StIdle = 4'b0010,
    StRd   = 4'b0100,
    StEx   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StClr: begin
        cmd_o.clr = 1'b1;
        if (st_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StRd;
        end
      end
      StRd: begin
        cmd_o.rd = 1'b1;
        state_d  = StEx;
      end
      StEx: begin
        if (st_i.out_free) begin
          cmd_o.ex = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StClr;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/sacl_dp.sv =====
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath: configuration, set rows in memory, lookup, LRU choice, totals.
// ----------------------------------------------------------------------------
module sacl_dp import sacl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  cmd_t                cmd_i,
  output status_t             st_o,
  input  logic                action_i,
  input  logic [AddrW-1:0]    address_i,
  input  logic                rsp_ready_i,
  output logic                rsp_valid_o,
  output logic                hit_o,
  output logic                miss_o,
  output logic                eviction_o,
  output logic                second_hit_o,
  output logic [TotalW-1:0]   hit_total_o,
  output logic [TotalW-1:0]   miss_total_o,
  output logic [TotalW-1:0]   eviction_total_o
);

  // Configuration.
  logic [3:0] set_bits_q;
  logic [3:0] ways_q;
  logic [5:0] block_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 4'd0;
      ways_q       <= 4'd1;
      block_bits_q <= 6'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSetBits:   set_bits_q   <= cfg_wdata_i[3:0];
        CfgWays:      ways_q       <= cfg_wdata_i[3:0];
        CfgBlockBits: block_bits_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Address split.
  logic [3:0]         s_eff;
  logic [WayCntW-1:0] nways;
  logic [6:0]         shift_sum;
  logic [AddrW-1:0]   set_shift;
  logic [SetIdxW-1:0] idx_mask;
  logic [SetIdxW-1:0] set_q;
  logic [TagW-1:0]    tag_q;
  logic               action_q;

  always_comb begin
    s_eff     = (set_bits_q > 4'(SetIdxW)) ? 4'(SetIdxW) : set_bits_q;
    nways     = (ways_q == '0) ? WayCntW'(1) :
                (ways_q > WayCntW'(NumWays)) ? WayCntW'(NumWays) : ways_q;
    shift_sum = 7'(block_bits_q) + 7'(s_eff);
    set_shift = address_i >> block_bits_q;
    idx_mask  = SetIdxW'(((SetIdxW+1)'(1)) << s_eff) - SetIdxW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q    <= set_shift[SetIdxW-1:0] & idx_mask;
      tag_q    <= shift_sum[6] ? '0 : (address_i >> shift_sum[5:0]);
      action_q <= action_i;
    end
  end

  // Clearing pass over the valid rows.
  logic [SetIdxW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + SetIdxW'(1);
    end
  end

  // Set rows.
  logic [NumWays-1:0]             valid_mem [NumSets];
  logic [NumWays-1:0][TagW-1:0]   tag_mem   [NumSets];
  logic [NumWays-1:0][StampW-1:0] stamp_mem [NumSets];

  logic [NumWays-1:0]             v_row_q, v_row_d;
  logic [NumWays-1:0][TagW-1:0]   tag_row_q, tag_row_d;
  logic [NumWays-1:0][StampW-1:0] stamp_row_q, stamp_row_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      valid_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.ex) begin
      valid_mem[set_q] <= v_row_d;
      tag_mem[set_q]   <= tag_row_d;
      stamp_mem[set_q] <= stamp_row_d;
    end
    if (cmd_i.rd) begin
      v_row_q     <= valid_mem[set_q];
      tag_row_q   <= tag_mem[set_q];
      stamp_row_q <= stamp_mem[set_q];
    end
  end

  // Lookup and replacement choice.
  logic [StampW-1:0] use_clock_q;
  logic              hit_f, inv_f, evict;
  logic [WayW-1:0]   hit_w, inv_w, vic_w, sel_w;
  logic [StampW-1:0] stamp_new;

  always_comb begin
    hit_f = 1'b0;
    inv_f = 1'b0;
    hit_w = '0;
    inv_w = '0;
    vic_w = '0;
    // Scan downward so the lowest matching way wins.
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (WayCntW'(w) < nways) begin
        if (v_row_q[w] && tag_row_q[w] == tag_q) begin
          hit_f = 1'b1;
          hit_w = WayW'(w);
        end
        if (!v_row_q[w]) begin
          inv_f = 1'b1;
          inv_w = WayW'(w);
        end
      end
    end
    for (int w = 1; w < NumWays; w++) begin
      if (WayCntW'(w) < nways && stamp_row_q[w] < stamp_row_q[vic_w]) vic_w = WayW'(w);
    end
    evict = !hit_f && !inv_f;
    sel_w = hit_f ? hit_w : (inv_f ? inv_w : vic_w);
    // An eviction burns one stamp; the second access of a modify takes another.
    stamp_new   = use_clock_q + StampW'(evict) + StampW'(action_q);
    v_row_d     = v_row_q;
    tag_row_d   = tag_row_q;
    stamp_row_d = stamp_row_q;
    v_row_d[sel_w]     = 1'b1;
    tag_row_d[sel_w]   = tag_q;
    stamp_row_d[sel_w] = stamp_new;
  end

  // Totals and result register.
  logic [TotalW-1:0] hit_tot_q, miss_tot_q, evict_tot_q;
  logic [TotalW:0]   hit_sum, miss_sum, evict_sum;
  logic              out_valid_q;

  assign hit_sum   = {1'b0, hit_tot_q} + (TotalW+1)'(hit_f) + (TotalW+1)'(action_q);
  assign miss_sum  = {1'b0, miss_tot_q} + (TotalW+1)'(!hit_f);
  assign evict_sum = {1'b0, evict_tot_q} + (TotalW+1)'(evict);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_clock_q <= '0;
      hit_tot_q   <= '0;
      miss_tot_q  <= '0;
      evict_tot_q <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.ex) begin
      use_clock_q <= stamp_new + StampW'(1);
      hit_tot_q   <= hit_sum[TotalW] ? '1 : hit_sum[TotalW-1:0];
      miss_tot_q  <= miss_sum[TotalW] ? '1 : miss_sum[TotalW-1:0];
      evict_tot_q <= evict_sum[TotalW] ? '1 : evict_sum[TotalW-1:0];
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ex) begin
      hit_o        <= hit_f;
      miss_o       <= !hit_f;
      eviction_o   <= evict;
      second_hit_o <= action_q;
    end
  end

  assign rsp_valid_o      = out_valid_q;
  assign hit_total_o      = hit_tot_q;
  assign miss_total_o     = miss_tot_q;
  assign eviction_total_o = evict_tot_q;

  assign st_o.clr_last = (clr_cnt_q == SetIdxW'(NumSets - 1));
  assign st_o.out_free = !out_valid_q || rsp_ready_i;

endmodule
